/* rtl/core/pma_pkg.sv */
// Shared types and constants of the polygon mesh area accumulator.
`timescale 1ns / 1ps
package pma_pkg;

    // Default coordinate width; coordinates carry 8 fraction bits by default,
    // areas come out with twice as many.
    localparam int COORD_BITS_DEF = 24;

    localparam int POLY_W = 56;
    localparam int MESH_W = 63;
    localparam int M_DW   = ((POLY_W + MESH_W + 7) / 8) * 8;

    localparam logic [POLY_W-1:0] POLY_MAX = '1;
    localparam logic [MESH_W-1:0] MESH_MAX = '1;

    // What the back end has to do with one queued vertex.
    typedef struct packed {
        logic do_tri;   // add the fan triangle closed by this vertex
        logic emit;     // this vertex closes a polygon
        logic mesh;     // this vertex closes the mesh
    } pma_ctl_t;

    localparam int CTL_W = $bits(pma_ctl_t);

endpackage

/* rtl/core/pma_front.sv */
// Front end: takes vertices, tracks the polygon fan and queues the work.
`timescale 1ns / 1ps
module pma_front #(
    parameter int COORD_BITS = pma_pkg::COORD_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [3*COORD_BITS-1:0]                     vtx_in,
    input  logic                                        polygon_end,
    input  logic                                        mesh_end,
    input  logic                                        q_full,
    output logic                                        q_push,
    output logic [pma_pkg::CTL_W+9*COORD_BITS-1:0]      q_wdata
);
    import pma_pkg::*;

    logic [1:0]              count_reg, count_next;
    logic [3*COORD_BITS-1:0] first_reg, first_next;
    logic [3*COORD_BITS-1:0] prev_reg;
    logic                    accept;
    pma_ctl_t                ctl;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        ctl.do_tri = (count_reg == 2'd2);
        ctl.emit   = polygon_end || mesh_end;
        ctl.mesh   = mesh_end;
        // Vertices that neither close a triangle nor a polygon need no back-end work.
        q_push     = accept && (ctl.do_tri || ctl.emit);
        q_wdata    = {ctl, vtx_in, prev_reg, first_reg};
        first_next = first_reg;
        count_next = count_reg;
        if (accept) begin
            if (count_reg == 2'd0) begin
                first_next = vtx_in;
            end
            if (ctl.emit) begin
                count_next = 2'd0;
            end else if (count_reg != 2'd2) begin
                count_next = count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        first_reg <= first_next;
        if (accept) begin
            prev_reg <= vtx_in;
        end
    end

endmodule

/* rtl/core/pma_queue.sv */
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module pma_queue #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] wdata,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign rdata = mem[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/core/pma_back.sv */
// Back end: serial Heron area unit, polygon and mesh sums, result register.
`timescale 1ns / 1ps
module pma_back #(
    parameter int COORD_BITS = pma_pkg::COORD_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        q_valid,
    input  logic [pma_pkg::CTL_W+9*COORD_BITS-1:0]      q_rdata,
    output logic                                        q_pop,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [pma_pkg::M_DW-1:0]                    m_tdata,
    output logic                                        m_tlast
);
    import pma_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int QDW = CTL_W + 9 * CB;
    localparam int SW  = 2 * CB + 2;            // squared side length
    localparam int DW  = SW + 1;                // |A + B - C|
    localparam int RW  = 2 * DW;                // radicand
    localparam int QW  = RW / 2;                // square root
    localparam int REMW = QW + 2;
    localparam int CW  = $clog2(QW);
    localparam int AW  = QW - 2;                // triangle area
    localparam int XW  = (AW > POLY_W) ? AW : POLY_W;

    localparam logic [3:0] OP_AB      = 4'd9;
    localparam logic [3:0] OP_DD      = 4'd10;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_STORE = 7'b0001000,
        ST_ROOT  = 7'b0010000,
        ST_SUM   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [QDW-1:0]    ent_reg, ent_next;
    logic [SW-1:0]     side_reg [3];
    logic [SW-1:0]     side_next [3];
    logic [3:0]        op_reg, op_next;
    logic [1:0]        sidx_reg, sidx_next;
    logic [1:0]        cidx_reg, cidx_next;
    logic [RW-1:0]     mcand_reg, mcand_next;
    logic [DW-1:0]     mplier_reg, mplier_next;
    logic [RW-1:0]     prod_reg, prod_next;
    logic [RW-1:0]     t_reg, t_next;
    logic [RW-1:0]     rad_reg, rad_next;
    logic [REMW-1:0]   rem_reg, rem_next;
    logic [QW-1:0]     root_reg, root_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [POLY_W-1:0] ps_reg, ps_next;
    logic [MESH_W-1:0] ms_reg, ms_next;
    logic              mv_reg, mv_next;
    logic [POLY_W-1:0] mpoly_reg, mpoly_next;
    logic [MESH_W-1:0] mtot_reg, mtot_next;
    logic              mlast_reg, mlast_next;

    pma_ctl_t          ctl;
    logic [CB-1:0]     vtx [3][3];
    logic [CB-1:0]     pa, pb;
    logic [CB:0]       dif, dif_abs;
    logic [DW-1:0]     ab, cc, dd;
    logic [REMW-1:0]   rem_sh, trial;
    logic [XW-1:0]     area_x;
    logic [POLY_W-1:0] area;
    logic [POLY_W:0]   ps_add;
    logic [MESH_W:0]   ms_add;

    assign ctl      = ent_reg[QDW-1 -: CTL_W];
    assign m_tvalid = mv_reg;
    assign m_tdata  = M_DW'({mtot_reg, mpoly_reg});
    assign m_tlast  = mlast_reg;

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) begin
                vtx[v][k] = ent_reg[(3*v+k)*CB +: CB];
            end
        end
        // Side 0 is first-prev, side 1 first-new, side 2 new-prev.
        pa      = (sidx_reg == 2'd2) ? vtx[2][cidx_reg] : vtx[0][cidx_reg];
        pb      = (sidx_reg == 2'd1) ? vtx[2][cidx_reg] : vtx[1][cidx_reg];
        dif     = {pa[CB-1], pa} - {pb[CB-1], pb};
        dif_abs = dif[CB] ? ((~dif) + (CB+1)'(1)) : dif;

        ab = DW'(side_reg[0]) + DW'(side_reg[1]);
        cc = DW'(side_reg[2]);
        dd = (ab >= cc) ? (ab - cc) : (cc - ab);

        rem_sh = {rem_reg[REMW-3:0], rad_reg[RW-1 -: 2]};
        trial  = {root_reg, 2'b01};

        area_x = XW'(root_reg >> 2);
        area   = (area_x > XW'(POLY_MAX)) ? POLY_MAX : area_x[POLY_W-1:0];
        if (!ctl.do_tri) begin
            area = '0;
        end
        ps_add = {1'b0, ps_reg} + {1'b0, area};
        ms_add = {1'b0, ms_reg} + (MESH_W+1)'(ps_reg);
    end

    always_comb begin
        state_next  = state_reg;
        ent_next    = ent_reg;
        side_next   = side_reg;
        op_next     = op_reg;
        sidx_next   = sidx_reg;
        cidx_next   = cidx_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        t_next      = t_reg;
        rad_next    = rad_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        cnt_next    = cnt_reg;
        ps_next     = ps_reg;
        ms_next     = ms_reg;
        mv_next     = mv_reg && !m_tready;
        mpoly_next  = mpoly_reg;
        mtot_next   = mtot_reg;
        mlast_next  = mlast_reg;
        q_pop       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    ent_next  = q_rdata;
                    for (int s = 0; s < 3; s++) begin
                        side_next[s] = '0;
                    end
                    op_next   = '0;
                    sidx_next = '0;
                    cidx_next = '0;
                    state_next = q_rdata[QDW-1] ? ST_LOAD : ST_SUM;
                end
            end
            ST_LOAD: begin
                prod_next = '0;
                if (op_reg == OP_AB) begin
                    mcand_next  = RW'(side_reg[0]);
                    mplier_next = DW'(side_reg[1]);
                end else if (op_reg == OP_DD) begin
                    mcand_next  = RW'(dd);
                    mplier_next = dd;
                end else begin
                    mcand_next  = RW'(dif_abs[CB-1:0]);
                    mplier_next = DW'(dif_abs[CB-1:0]);
                end
                state_next = ST_MUL;
            end
            ST_MUL: begin
                // Shift-add multiply; stops as soon as no multiplier bits are left.
                if (mplier_reg == '0) begin
                    state_next = ST_STORE;
                end else begin
                    if (mplier_reg[0]) begin
                        prod_next = prod_reg + mcand_reg;
                    end
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end
            ST_STORE: begin
                if (op_reg == OP_DD) begin
                    rad_next   = (prod_reg > t_reg) ? '0 : (t_reg - prod_reg);
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = CW'(QW - 1);
                    state_next = ST_ROOT;
                end else begin
                    if (op_reg == OP_AB) begin
                        t_next = prod_reg << 2;
                    end else begin
                        side_next[sidx_reg] = side_reg[sidx_reg] + prod_reg[SW-1:0];
                        if (cidx_reg == 2'd2) begin
                            cidx_next = 2'd0;
                            sidx_next = sidx_reg + 2'd1;
                        end else begin
                            cidx_next = cidx_reg + 2'd1;
                        end
                    end
                    op_next    = op_reg + 4'd1;
                    state_next = ST_LOAD;
                end
            end
            ST_ROOT: begin
                // Restoring square root, one result bit per cycle.
                rad_next = rad_reg << 2;
                if (rem_sh >= trial) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[QW-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[QW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                ps_next    = ps_add[POLY_W] ? POLY_MAX : ps_add[POLY_W-1:0];
                state_next = ctl.emit ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mpoly_next = ps_reg;
                    mtot_next  = ms_add[MESH_W] ? MESH_MAX : ms_add[MESH_W-1:0];
                    mlast_next = ctl.mesh;
                    ps_next    = '0;
                    ms_next    = ctl.mesh ? '0 : mtot_next;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ps_reg    <= '0;
            ms_reg    <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ps_reg    <= ps_next;
            ms_reg    <= ms_next;
            mv_reg    <= mv_next;
        end
        ent_reg    <= ent_next;
        side_reg   <= side_next;
        op_reg     <= op_next;
        sidx_reg   <= sidx_next;
        cidx_reg   <= cidx_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        t_reg      <= t_next;
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        cnt_reg    <= cnt_next;
        mpoly_reg  <= mpoly_next;
        mtot_reg   <= mtot_next;
        mlast_reg  <= mlast_next;
    end

endmodule

/* rtl/core/polygon_mesh_area_accumulator.sv */
// Polygon mesh area accumulator: vertex stream in, polygon and mesh areas out.
//
// Vertices enter on the s_ channel, one item per vertex, in polygon order.
// s_tlast marks the last vertex of a polygon and s_tuser the last vertex of
// the mesh (which also closes the polygon). From the third vertex of a
// polygon on, each vertex closes a fan triangle whose Heron area is added
// to the polygon sum. Each closed polygon gives one item on the m_ channel
// with its area and the running mesh total; m_tlast marks the mesh's end.
// Vertices that close neither a triangle nor a polygon never reach the back
// end; a closing vertex without a triangle only passes through the back
// end's idle, sum and emit states. A vertex that closes a triangle occupies
// the back end while the single shift-add multiplier squares the side
// differences and forms the two long products, and while the bit-serial
// root unit extracts the square root. A two-entry queue lets the front end
// keep taking vertices meanwhile. The result register holds an item while
// m_tready is low; the back end waits on it only when the next result is
// ready. Reset clears both sums, the vertex count, the queue and the result
// register.
`timescale 1ns / 1ps
module polygon_mesh_area_accumulator #(
    parameter int COORD_BITS = pma_pkg::COORD_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // vertex_x, vertex_y, vertex_z from bit 0 up, zero padded
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]       s_tdata,
    input  logic                                    s_tlast,   // polygon_end
    input  logic                                    s_tuser,   // mesh_end
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // polygon_area, total_area from bit 0 up, zero padded
    output logic [pma_pkg::M_DW-1:0]                m_tdata,
    output logic                                    m_tlast    // mesh_done
);
    import pma_pkg::*;

    localparam int QDW = CTL_W + 9 * COORD_BITS;

    logic           q_push, q_full, q_pop, q_valid;
    logic [QDW-1:0] q_wdata, q_rdata;

    pma_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .vtx_in      (s_tdata[3*COORD_BITS-1:0]),
        .polygon_end (s_tlast),
        .mesh_end    (s_tuser),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    pma_queue #(.DW(QDW)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rdata   (q_rdata)
    );

    pma_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/core/pma_checker.sv */
// Port-level checks of the polygon mesh area accumulator, bound to the top level.
`timescale 1ns / 1ps
module pma_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [pma_pkg::M_DW-1:0]   m_tdata,
    input logic                       m_tlast
);
    import pma_pkg::*;

    // The mesh total always includes the polygon reported with it.
    a_total_covers_poly: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (MESH_W'(m_tdata[POLY_W-1:0]) <= m_tdata[POLY_W +: MESH_W]))
        else $error("total area below polygon area");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind polygon_mesh_area_accumulator pma_checker u_pma_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
